// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// antecedent holds in this cycle, consequent in the same cycle
`define CBCR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
   else $error("implication check failed");

// antecedent holds in this cycle, consequent in the next one
`define CBCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
   else $error("next-cycle check failed");

`else

`define CBCR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CBCR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/cbcr_pkg.sv
package cbcr_pkg;

   // field widths
   localparam int POS_W = 24;
   localparam int LEN_W = 20;
   localparam int CSR_W = 8;
   localparam int CSR_IDX_W = 1;

   // internal working widths
   localparam int G_W = 28;
   localparam int SQ_W = 54;
   localparam int ROOT_W = SQ_W / 2;
   localparam int QUO_W = 28;
   localparam int DEN_W = ROOT_W + 1;
   localparam int NUM_W = QUO_W + DEN_W;
   localparam int SUM_W = QUO_W + 2;

   // register reset values
   localparam logic [CSR_W-1:0] SHRINK_RST = 8'd3;
   localparam logic [CSR_W-1:0] BIAS_RST = 8'd43;

   // normal length used when the centre sits inside the box (256.0 in half steps)
   localparam logic [ROOT_W-1:0] MAG_ONE = ROOT_W'(512);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHRINK = 1'b0,
      CSR_BIAS = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      SIDE_RIGHT = 2'd0,
      SIDE_LEFT = 2'd1,
      SIDE_BOTTOM = 2'd2,
      SIDE_TOP = 2'd3
   } side_type;

   // per item context carried down the long pipeline
   typedef struct packed {
      logic hit;
      side_type side;
      logic signed [POS_W-1:0] cx;
      logic signed [POS_W-1:0] cy;
      logic [LEN_W-1:0] d;
      logic signed [G_W-1:0] g;
   } ctx_type;

endpackage

// File: rtl/circle_box_contact_resolve_unit.sv
// a word accepted with start is answered by a one-cycle rsp_valid from the output register
// throughput: one word per cycle; busy stays low, every stage advances each cycle
// the normal length square root (27 stages) and the push division (28 stages)
// set the depth; one root bit and one quotient bit are resolved per stage
// reset: synchronous, active high; clears stage valid bits and loads shrink 3, bias 43
// the receiver cannot stall, so results leave in order with no back pressure
`include "assert_macros.svh"

module circle_box_contact_resolve_unit (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [cbcr_pkg::POS_W-1:0] req_circle_x,
   input  logic signed [cbcr_pkg::POS_W-1:0] req_circle_y,
   input  logic [cbcr_pkg::LEN_W-1:0] req_circle_diameter,
   input  logic signed [cbcr_pkg::POS_W-1:0] req_box_x,
   input  logic signed [cbcr_pkg::POS_W-1:0] req_box_y,
   input  logic [cbcr_pkg::LEN_W-1:0] req_box_width,
   input  logic [cbcr_pkg::LEN_W-1:0] req_box_height,
   input  logic csr_we,
   input  logic [cbcr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cbcr_pkg::CSR_W-1:0] csr_wdata,
   output logic rsp_valid,
   output logic rsp_hit,
   output logic [1:0] rsp_side,
   output logic signed [cbcr_pkg::POS_W-1:0] rsp_new_x,
   output logic signed [cbcr_pkg::POS_W-1:0] rsp_new_y
);

   localparam int PW = cbcr_pkg::POS_W;
   localparam int LW = cbcr_pkg::LEN_W;
   localparam int GW = cbcr_pkg::G_W;
   localparam int SQW = cbcr_pkg::SQ_W;
   localparam int RW = cbcr_pkg::ROOT_W;
   localparam int QW = cbcr_pkg::QUO_W;
   localparam int DW = cbcr_pkg::DEN_W;
   localparam int NW = cbcr_pkg::NUM_W;
   localparam int SW = cbcr_pkg::SUM_W;
   localparam int CW = cbcr_pkg::CSR_W;

   logic accept;
   logic [CW-1:0] shrink_ff;
   logic [CW-1:0] bias_ff;

   assign busy = 1'b0;
   assign accept = start & ~busy;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         shrink_ff <= cbcr_pkg::SHRINK_RST;
         bias_ff <= cbcr_pkg::BIAS_RST;
      end else if (csr_we) begin
         unique case (cbcr_pkg::csr_idx_type'(csr_index))
            cbcr_pkg::CSR_SHRINK: shrink_ff <= csr_wdata;
            cbcr_pkg::CSR_BIAS: bias_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- stage a: extend and first sums ----------------
   logic signed [GW-1:0] cx_w, cy_w, d_w, bx_w, by_w, bw_w, bh_w, shr_w, r2_w;
   logic a_vld_ff;
   logic signed [GW-1:0] a_r2_ff, a_sx_ff, a_sy_ff, a_ccx_ff, a_ccy_ff;
   logic signed [GW-1:0] a_blx_ff, a_bhx_ff, a_bly_ff, a_bhy_ff;
   logic signed [GW-1:0] a_cxe_ff, a_bxe_ff, a_cye_ff, a_bye_ff;
   logic signed [GW-1:0] a_cxw_ff, a_bxw_ff, a_cyw_ff, a_byw_ff, a_bw_ff, a_bh_ff;
   logic signed [PW-1:0] a_cx_ff, a_cy_ff;
   logic [LW-1:0] a_d_ff;

   assign cx_w = GW'(req_circle_x);
   assign cy_w = GW'(req_circle_y);
   assign bx_w = GW'(req_box_x);
   assign by_w = GW'(req_box_y);
   assign d_w = GW'(signed'({1'b0, req_circle_diameter}));
   assign bw_w = GW'(signed'({1'b0, req_box_width}));
   assign bh_w = GW'(signed'({1'b0, req_box_height}));
   assign shr_w = GW'(signed'({1'b0, shrink_ff}));
   assign r2_w = d_w - shr_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      a_r2_ff <= r2_w;
      a_sx_ff <= (cx_w <<< 1) + r2_w - ((bx_w <<< 1) + bw_w);
      a_sy_ff <= (cy_w <<< 1) + r2_w - ((by_w <<< 1) + bh_w);
      a_ccx_ff <= (cx_w <<< 1) + d_w;
      a_ccy_ff <= (cy_w <<< 1) + d_w;
      a_blx_ff <= bx_w <<< 1;
      a_bly_ff <= by_w <<< 1;
      a_bhx_ff <= (bx_w + bw_w) <<< 1;
      a_bhy_ff <= (by_w + bh_w) <<< 1;
      a_cxe_ff <= cx_w + d_w;
      a_cye_ff <= cy_w + d_w;
      a_bxe_ff <= bx_w + bw_w;
      a_bye_ff <= by_w + bh_w;
      a_cxw_ff <= cx_w;
      a_cyw_ff <= cy_w;
      a_bxw_ff <= bx_w;
      a_byw_ff <= by_w;
      a_bw_ff <= bw_w;
      a_bh_ff <= bh_w;
      a_cx_ff <= req_circle_x;
      a_cy_ff <= req_circle_y;
      a_d_ff <= req_circle_diameter;
   end

   // ---------------- stage b: distances, clamp, overlaps ----------------
   logic signed [GW-1:0] px_in, py_in;
   logic b_vld_ff;
   logic signed [GW-1:0] b_dx_ff, b_dy_ff, b_gx_ff, b_gy_ff, b_hov_ff, b_vov_ff;
   logic signed [GW-1:0] b_r2_ff, b_bw_ff, b_bh_ff;
   logic b_right_ff, b_bottom_ff;
   logic signed [PW-1:0] b_cx_ff, b_cy_ff;
   logic [LW-1:0] b_d_ff;

   // clamp the centre onto the box
   always_comb begin
      px_in = (a_ccx_ff < a_bhx_ff) ? a_ccx_ff : a_bhx_ff;
      if (px_in < a_blx_ff) begin
         px_in = a_blx_ff;
      end
      py_in = (a_ccy_ff < a_bhy_ff) ? a_ccy_ff : a_bhy_ff;
      if (py_in < a_bly_ff) begin
         py_in = a_bly_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_dx_ff <= a_sx_ff[GW-1] ? -a_sx_ff : a_sx_ff;
      b_dy_ff <= a_sy_ff[GW-1] ? -a_sy_ff : a_sy_ff;
      b_gx_ff <= px_in - a_ccx_ff;
      b_gy_ff <= py_in - a_ccy_ff;
      b_hov_ff <= ((a_cxe_ff < a_bxe_ff) ? a_cxe_ff : a_bxe_ff)
                - ((a_cxw_ff > a_bxw_ff) ? a_cxw_ff : a_bxw_ff);
      b_vov_ff <= ((a_cye_ff < a_bye_ff) ? a_cye_ff : a_bye_ff)
                - ((a_cyw_ff > a_byw_ff) ? a_cyw_ff : a_byw_ff);
      b_right_ff <= a_cxe_ff > a_bxe_ff;
      b_bottom_ff <= a_cye_ff > a_bye_ff;
      b_r2_ff <= a_r2_ff;
      b_bw_ff <= a_bw_ff;
      b_bh_ff <= a_bh_ff;
      b_cx_ff <= a_cx_ff;
      b_cy_ff <= a_cy_ff;
      b_d_ff <= a_d_ff;
   end

   // ---------------- stage c: coarse test, squares of the normal ----------------
   logic horiz_in;
   cbcr_pkg::side_type side_in;
   logic signed [2*GW-1:0] gx2_full, gy2_full;
   logic c_vld_ff, c_far_ff, c_near_ff;
   logic [LW-1:0] c_ex_ff, c_ey_ff;
   logic [SQW-1:0] c_gx2_ff, c_gy2_ff;
   logic signed [LW:0] c_r2_ff;
   cbcr_pkg::ctx_type c_ctx_ff;

   assign horiz_in = b_hov_ff < b_vov_ff;
   assign gx2_full = b_gx_ff * b_gx_ff;
   assign gy2_full = b_gy_ff * b_gy_ff;

   always_comb begin
      if (horiz_in) begin
         side_in = b_right_ff ? cbcr_pkg::SIDE_RIGHT : cbcr_pkg::SIDE_LEFT;
      end else begin
         side_in = b_bottom_ff ? cbcr_pkg::SIDE_BOTTOM : cbcr_pkg::SIDE_TOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_far_ff <= (b_dx_ff > b_bw_ff + b_r2_ff) || (b_dy_ff > b_bh_ff + b_r2_ff);
      c_near_ff <= (b_dx_ff <= b_bw_ff) || (b_dy_ff <= b_bh_ff);
      c_ex_ff <= LW'(b_dx_ff - b_bw_ff);
      c_ey_ff <= LW'(b_dy_ff - b_bh_ff);
      c_gx2_ff <= SQW'(gx2_full);
      c_gy2_ff <= SQW'(gy2_full);
      c_r2_ff <= b_r2_ff[LW:0];
      c_ctx_ff.hit <= 1'b0;
      c_ctx_ff.side <= side_in;
      c_ctx_ff.cx <= b_cx_ff;
      c_ctx_ff.cy <= b_cy_ff;
      c_ctx_ff.d <= b_d_ff;
      c_ctx_ff.g <= horiz_in ? b_gx_ff : b_gy_ff;
   end

   // ---------------- stage d: corner squares, squared length ----------------
   logic signed [2*LW+1:0] r2sq_full;
   logic d_vld_ff, d_far_ff, d_near_ff;
   logic [2*LW:0] d_e2_ff, d_r2sq_ff;
   logic [SQW-1:0] d_n_ff;
   cbcr_pkg::ctx_type d_ctx_ff;

   assign r2sq_full = c_r2_ff * c_r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_far_ff <= c_far_ff;
      d_near_ff <= c_near_ff;
      d_e2_ff <= (2*LW+1)'(c_ex_ff * c_ex_ff) + (2*LW+1)'(c_ey_ff * c_ey_ff);
      d_r2sq_ff <= r2sq_full[2*LW:0];
      d_n_ff <= c_gx2_ff + c_gy2_ff;
      d_ctx_ff <= c_ctx_ff;
   end

   // ---------------- stage e: hit decision, root pipeline entry ----------------
   logic hit_in;
   cbcr_pkg::ctx_type e_ctx_in;
   logic q_vld_ff [0:RW];
   logic [RW:0] q_rem_ff [0:RW];
   logic [RW-1:0] q_root_ff [0:RW];
   logic [SQW-1:0] q_n_ff [0:RW];
   cbcr_pkg::ctx_type q_ctx_ff [0:RW];

   assign hit_in = ~d_far_ff & (d_near_ff | (d_e2_ff <= d_r2sq_ff));

   always_comb begin
      e_ctx_in = d_ctx_ff;
      e_ctx_in.hit = hit_in;
      if (!hit_in) begin
         e_ctx_in.side = cbcr_pkg::SIDE_RIGHT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff[0] <= 1'b0;
      end else begin
         q_vld_ff[0] <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      q_rem_ff[0] <= '0;
      q_root_ff[0] <= '0;
      q_n_ff[0] <= d_n_ff;
      q_ctx_ff[0] <= e_ctx_in;
   end

   // ---------------- square root: one root bit per stage ----------------
   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      logic [RW+2:0] cur_in, trial_in, diff_in;
      logic ge_in;

      assign cur_in = {q_rem_ff[k], q_n_ff[k][SQW-1 -: 2]};
      assign trial_in = {1'b0, q_root_ff[k], 2'b01};
      assign ge_in = cur_in >= trial_in;
      assign diff_in = ge_in ? (cur_in - trial_in) : cur_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            q_vld_ff[k+1] <= 1'b0;
         end else begin
            q_vld_ff[k+1] <= q_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         q_rem_ff[k+1] <= diff_in[RW:0];
         q_root_ff[k+1] <= {q_root_ff[k][RW-2:0], ge_in};
         q_n_ff[k+1] <= q_n_ff[k] << 2;
         q_ctx_ff[k+1] <= q_ctx_ff[k];
      end
   end

   // ---------------- stage m: length fix-up, operand magnitudes ----------------
   logic [RW-1:0] mag_in;
   logic signed [RW+1:0] dm_in;
   logic m_vld_ff, m_neg_ff;
   logic [GW-2:0] m_absg_ff;
   logic [RW:0] m_absdm_ff;
   logic [RW-1:0] m_mag_ff;
   cbcr_pkg::ctx_type m_ctx_ff;

   assign mag_in = (q_root_ff[RW] == '0) ? cbcr_pkg::MAG_ONE : q_root_ff[RW];
   assign dm_in = (RW+2)'(signed'({1'b0, q_ctx_ff[RW].d})) - (RW+2)'(signed'({1'b0, mag_in}));

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= q_vld_ff[RW];
      end
   end

   // push of -g * (d - mag) is negative when both factors share a sign
   always_ff @(posedge clock) begin
      m_neg_ff <= ~(q_ctx_ff[RW].g[GW-1] ^ dm_in[RW+1]);
      m_absg_ff <= q_ctx_ff[RW].g[GW-1] ? (GW-1)'(-q_ctx_ff[RW].g)
                                        : (GW-1)'(q_ctx_ff[RW].g);
      m_absdm_ff <= dm_in[RW+1] ? (RW+1)'(-dm_in) : (RW+1)'(dm_in);
      m_mag_ff <= mag_in;
      m_ctx_ff <= q_ctx_ff[RW];
   end

   // ---------------- stage p: product plus rounding half ----------------
   logic v_vld_ff [0:QW];
   logic [DW-1:0] v_rem_ff [0:QW];
   logic [QW-1:0] v_lo_ff [0:QW];
   logic [QW-1:0] v_quo_ff [0:QW];
   logic [DW-1:0] v_den_ff [0:QW];
   logic v_neg_ff [0:QW];
   cbcr_pkg::ctx_type v_ctx_ff [0:QW];
   logic [NW-1:0] num_in;

   assign num_in = NW'(m_absg_ff * m_absdm_ff) + NW'(m_mag_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_vld_ff[0] <= 1'b0;
      end else begin
         v_vld_ff[0] <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      v_rem_ff[0] <= num_in[NW-1:QW];
      v_lo_ff[0] <= num_in[QW-1:0];
      v_quo_ff[0] <= '0;
      v_den_ff[0] <= {m_mag_ff, 1'b0};
      v_neg_ff[0] <= m_neg_ff;
      v_ctx_ff[0] <= m_ctx_ff;
   end

   // ---------------- restoring division: one quotient bit per stage ----------------
   for (genvar j = 0; j < QW; j++) begin : g_div
      logic [DW:0] cur_in, diff_in;
      logic ge_in;

      assign cur_in = {v_rem_ff[j], v_lo_ff[j][QW-1]};
      assign ge_in = cur_in >= {1'b0, v_den_ff[j]};
      assign diff_in = ge_in ? (cur_in - {1'b0, v_den_ff[j]}) : cur_in;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_vld_ff[j+1] <= 1'b0;
         end else begin
            v_vld_ff[j+1] <= v_vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         v_rem_ff[j+1] <= diff_in[DW-1:0];
         v_lo_ff[j+1] <= v_lo_ff[j] << 1;
         v_quo_ff[j+1] <= {v_quo_ff[j][QW-2:0], ge_in};
         v_den_ff[j+1] <= v_den_ff[j];
         v_neg_ff[j+1] <= v_neg_ff[j];
         v_ctx_ff[j+1] <= v_ctx_ff[j];
      end
   end

   // ---------------- output stage: apply push and bias, saturate ----------------
   cbcr_pkg::ctx_type f_ctx;
   logic signed [SW-1:0] push_in, bias_in, sum_x_in, sum_y_in;
   logic signed [PW-1:0] new_x_in, new_y_in;
   logic horiz_side;

   localparam logic signed [SW-1:0] POS_MAX = SW'((64'sd1 <<< (PW-1)) - 64'sd1);
   localparam logic signed [SW-1:0] POS_MIN = SW'(-(64'sd1 <<< (PW-1)));

   assign f_ctx = v_ctx_ff[QW];
   assign horiz_side = (f_ctx.side == cbcr_pkg::SIDE_RIGHT)
                    || (f_ctx.side == cbcr_pkg::SIDE_LEFT);

   always_comb begin
      push_in = v_neg_ff[QW] ? -SW'(signed'({1'b0, v_quo_ff[QW]}))
                             : SW'(signed'({1'b0, v_quo_ff[QW]}));
      // bias pushes against the sign of the vertical normal
      if (f_ctx.g[GW-1]) begin
         bias_in = SW'(signed'({1'b0, bias_ff}));
      end else if (f_ctx.g != '0) begin
         bias_in = -SW'(signed'({1'b0, bias_ff}));
      end else begin
         bias_in = '0;
      end
      sum_x_in = SW'(f_ctx.cx) + push_in;
      sum_y_in = SW'(f_ctx.cy) + push_in + bias_in;
      new_x_in = f_ctx.cx;
      new_y_in = f_ctx.cy;
      if (f_ctx.hit && horiz_side) begin
         if (sum_x_in > POS_MAX) begin
            new_x_in = PW'(POS_MAX);
         end else if (sum_x_in < POS_MIN) begin
            new_x_in = PW'(POS_MIN);
         end else begin
            new_x_in = PW'(sum_x_in);
         end
      end
      if (f_ctx.hit && !horiz_side) begin
         if (sum_y_in > POS_MAX) begin
            new_y_in = PW'(POS_MAX);
         end else if (sum_y_in < POS_MIN) begin
            new_y_in = PW'(POS_MIN);
         end else begin
            new_y_in = PW'(sum_y_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= v_vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit <= f_ctx.hit;
      rsp_side <= f_ctx.side;
      rsp_new_x <= new_x_in;
      rsp_new_y <= new_y_in;
   end

   // ---------------- checks ----------------
   `CBCR_ASSERT_IMPL(a_miss_side, clock, reset, rsp_valid && !rsp_hit, rsp_side == cbcr_pkg::SIDE_RIGHT)
   `CBCR_ASSERT_IMPL(a_mag_nonzero, clock, reset, m_vld_ff, m_mag_ff != '0)
   `CBCR_ASSERT_IMPL(a_div_rem, clock, reset, v_vld_ff[QW], v_rem_ff[QW] < v_den_ff[QW])
   `CBCR_ASSERT_NEXT(a_enter, clock, reset, accept, a_vld_ff)

endmodule
